FILE: rtl/cbe_pkg.sv
`timescale 1ns / 1ps

package cbe_pkg;

    // Easing mode codes (curve_mode register)
    localparam logic [2:0] MODE_LINEAR      = 3'd0;
    localparam logic [2:0] MODE_HOLD        = 3'd1;
    localparam logic [2:0] MODE_EASE_IN     = 3'd2;
    localparam logic [2:0] MODE_EASE_OUT    = 3'd3;
    localparam logic [2:0] MODE_EASE_IN_OUT = 3'd4;
    localparam logic [2:0] MODE_EASE        = 3'd5;
    localparam logic [2:0] MODE_CUSTOM      = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_CURVE_MODE = 3'd0;
    localparam logic [2:0] REG_CTRL_X1    = 3'd1;
    localparam logic [2:0] REG_CTRL_Y1    = 3'd2;
    localparam logic [2:0] REG_CTRL_X2    = 3'd3;
    localparam logic [2:0] REG_CTRL_Y2    = 3'd4;

    // Field widths
    localparam int PROG_W = 18;
    localparam int CX_W   = 17;
    localparam int CY_W   = 18;
    localparam int MODE_W = 3;
    localparam int IDX_W  = 3;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // n/100 scaled by 2^f, rounded to nearest (elaboration only)
    function automatic longint hundredths(input longint n, input int f);
        hundredths = ((n << f) + 50) / 100;
    endfunction

endpackage

FILE: rtl/cbe_mul.sv
`timescale 1ns / 1ps

// Shared rounded fixed-point multiply: (a * t) >> FB, ties away from zero
module cbe_mul #(
    parameter int AW = 24,
    parameter int FB = 16
) (
    input  logic signed [AW-1:0] a,
    input  logic        [FB:0]   t,
    output logic signed [AW-1:0] p
);

    logic          neg;
    logic [AW-1:0] mag;
    logic [AW+FB:0] prod;
    logic [AW+FB:0] rnd;
    logic [AW+FB:0] shr;
    logic [AW-1:0] res;

    always_comb
    begin
        neg  = a[AW-1];
        mag  = neg ? (~a + 1'b1) : a;
        prod = (AW+FB+1)'(mag) * (AW+FB+1)'(t);
        rnd  = prod + ((AW+FB+1)'(1) << (FB-1));
        shr  = rnd >> FB;
        res  = shr[AW-1:0];
        p    = neg ? -$signed(res) : $signed(res);
    end

endmodule

FILE: rtl/cbe_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module cbe_div #(
    parameter int NW = 35,
    parameter int DW = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NW-1:0]       num,
    input  logic [DW-1:0]       den,
    output logic [NW-1:0]       quo,
    output cbe_pkg::div_sts_t   sts
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NW-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in next numerator bit, subtract when it fits
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo      = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

FILE: rtl/cubic_bezier_easing.sv
`timescale 1ns / 1ps

// Cubic Bezier easing (CSS timing function style). progress_in is clamped
// to [0,1] and mapped through curve_mode: linear, hold, the four CSS preset
// curves or a custom curve from ctrl_x1/y1/x2/y2 (x unsigned Q1.16, y signed
// Q2.16 by default). Bezier modes solve x(t)=progress by Newton steps,
// falling back to bisection, then evaluate y(t); the result saturates. One
// item at a time: in_stall is high from acceptance until the result is
// loaded into the output register, so the next input can transfer in the
// cycle after that load. Linear, hold and end points go from the input
// transfer straight to the output load. A Bezier item runs setup and one
// x(t) check, then per Newton step the slope, the bit-serial divider, the
// update and an x(t) check, and per bisection step a bound update and an
// x(t) check, then y(t) evaluation and the output load, all on one shared
// multiplier. A stalled output holds the finished item until the output
// register is free. Configure only while idle.
module cubic_bezier_easing #(
    parameter int FRAC_BITS    = 16,
    parameter int NEWTON_STEPS = 8,
    parameter int BISECT_STEPS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [cbe_pkg::PROG_W-1:0] progress_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cbe_pkg::PROG_W-1:0] eased_progress,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [cbe_pkg::IDX_W-1:0]  cfg_index,
    input  logic        [cbe_pkg::CY_W-1:0]   cfg_data
);

    localparam int W   = FRAC_BITS + 8;
    localparam int TW  = FRAC_BITS + 1;
    localparam int MW  = FRAC_BITS + 3;
    localparam int NW  = 2 * FRAC_BITS + 3;
    localparam int NCW = $clog2(NEWTON_STEPS + 1);
    localparam int BCW = $clog2(BISECT_STEPS + 1);

    localparam logic signed [W-1:0] ONE_S  = W'(longint'(1) << FRAC_BITS);
    localparam logic        [TW-1:0] ONE_T = TW'(longint'(1) << FRAC_BITS);
    localparam logic signed [W-1:0] LIM_HI = W'((longint'(2) << FRAC_BITS) - 1);
    localparam logic signed [W-1:0] LIM_LO = -W'(longint'(2) << FRAC_BITS);
    localparam logic signed [W-1:0] CAP_E  = W'(longint'(4) << FRAC_BITS);
    localparam longint TOL_RAW = ((longint'(1) << FRAC_BITS) + 999999) / 1000000;
    localparam logic signed [W-1:0] TOL = W'((TOL_RAW < 1) ? 1 : TOL_RAW);

    localparam logic signed [W-1:0] H42 = W'(cbe_pkg::hundredths(42, FRAC_BITS));
    localparam logic signed [W-1:0] H58 = W'(cbe_pkg::hundredths(58, FRAC_BITS));
    localparam logic signed [W-1:0] H25 = W'(cbe_pkg::hundredths(25, FRAC_BITS));
    localparam logic signed [W-1:0] H10 = W'(cbe_pkg::hundredths(10, FRAC_BITS));

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SETUP = 12'b0000_0000_0010,
        S_P1    = 12'b0000_0000_0100,
        S_P2    = 12'b0000_0000_1000,
        S_P3    = 12'b0000_0001_0000,
        S_CHK   = 12'b0000_0010_0000,
        S_S1    = 12'b0000_0100_0000,
        S_S2    = 12'b0000_1000_0000,
        S_SCHK  = 12'b0001_0000_0000,
        S_DIV   = 12'b0010_0000_0000,
        S_UPD   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_NEWTON = 2'd0,
        PH_BISECT = 2'd1,
        PH_YEVAL  = 2'd2
    } phase_t;

    // configuration registers
    logic [cbe_pkg::MODE_W-1:0] mode_reg;
    logic [cbe_pkg::CX_W-1:0]   cx1_reg, cx2_reg;
    logic [cbe_pkg::CY_W-1:0]   cy1_reg, cy2_reg;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    logic [NCW-1:0] ncnt_reg, ncnt_next;
    logic [BCW-1:0] bcnt_reg, bcnt_next;

    logic [TW-1:0] x_reg, x_next;
    logic [TW-1:0] t_reg, t_next;
    logic [TW-1:0] t0_reg, t0_next;
    logic [TW-1:0] t1_reg, t1_next;
    logic signed [W-1:0] r_reg, r_next;
    logic signed [W-1:0] err_reg, err_next;
    logic signed [W-1:0] p1x_reg, p1x_next, p2x_reg, p2x_next;
    logic signed [W-1:0] p1y_reg, p1y_next, p2y_reg, p2y_next;
    logic signed [W-1:0] ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    logic signed [W-1:0] ax3_reg, bx2_reg;
    logic qneg_reg, qneg_next;
    logic out_valid_reg, out_valid_next;
    logic signed [cbe_pkg::PROG_W-1:0] out_reg, out_next;

    logic signed [W-1:0] mul_a, mul_p, add_v, mul_sum;
    logic signed [W-1:0] prog_ext, e_val, mag_r, mag_e;
    logic [TW-1:0] p_clamp, t0n, t1n, tdiff;
    logic signed [W-1:0] cxc1, cxc2, cc, bc, ac, ccy, bcy, acy;
    logic signed [W-1:0] ysat;
    logic [MW-1:0] me;
    logic [NW-1:0] q_val, t_ext, one_ext;
    logic div_start;
    logic [NW-1:0] div_num;
    logic [W-1:0]  div_den;
    logic out_free;
    cbe_pkg::div_sts_t div_sts;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cbe_pkg::MODE_LINEAR;
            cx1_reg  <= cbe_pkg::CX_W'(16384);
            cy1_reg  <= cbe_pkg::CY_W'(6554);
            cx2_reg  <= cbe_pkg::CX_W'(16384);
            cy2_reg  <= cbe_pkg::CY_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbe_pkg::REG_CURVE_MODE: mode_reg <= cfg_data[cbe_pkg::MODE_W-1:0];
                cbe_pkg::REG_CTRL_X1:    cx1_reg  <= cfg_data[cbe_pkg::CX_W-1:0];
                cbe_pkg::REG_CTRL_Y1:    cy1_reg  <= cfg_data;
                cbe_pkg::REG_CTRL_X2:    cx2_reg  <= cfg_data[cbe_pkg::CX_W-1:0];
                cbe_pkg::REG_CTRL_Y2:    cy2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiply-add unit
    cbe_mul #(.AW(W), .FB(FRAC_BITS)) u_mul (
        .a (mul_a),
        .t (t_reg),
        .p (mul_p)
    );

    cbe_div #(.NW(NW), .DW(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (q_val),
        .sts   (div_sts)
    );

    always_comb
    begin
        mul_a = r_reg;
        add_v = '0;
        case (state_reg)
            S_P1:
            begin
                mul_a = (ph_reg == PH_YEVAL) ? ay_reg : ax_reg;
                add_v = (ph_reg == PH_YEVAL) ? by_reg : bx_reg;
            end
            S_P2:    add_v = (ph_reg == PH_YEVAL) ? cy_reg : cx_reg;
            S_S1:
            begin
                mul_a = ax3_reg;
                add_v = bx2_reg;
            end
            S_S2:    add_v = cx_reg;
            default: ;
        endcase
        mul_sum = mul_p + add_v;
    end

    // input clamp and custom point clamp
    always_comb
    begin
        prog_ext = W'(progress_in);
        if (prog_ext < 0)
            p_clamp = '0;
        else if (prog_ext > ONE_S)
            p_clamp = ONE_T;
        else
            p_clamp = prog_ext[TW-1:0];
        cxc1 = (W'(cx1_reg) > ONE_S) ? ONE_S : W'(cx1_reg);
        cxc2 = (W'(cx2_reg) > ONE_S) ? ONE_S : W'(cx2_reg);
    end

    // coefficients from the latched control points
    always_comb
    begin
        cc  = W'(3 * p1x_reg);
        bc  = W'(3 * (p2x_reg - p1x_reg)) - cc;
        ac  = ONE_S - cc - bc;
        ccy = W'(3 * p1y_reg);
        bcy = W'(3 * (p2y_reg - p1y_reg)) - ccy;
        acy = ONE_S - ccy - bcy;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SETUP)
        begin
            ax_reg  <= ac;
            bx_reg  <= bc;
            cx_reg  <= cc;
            ay_reg  <= acy;
            by_reg  <= bcy;
            cy_reg  <= ccy;
            ax3_reg <= W'(3 * ac);
            bx2_reg <= W'(2 * bc);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        ncnt_next      = ncnt_reg;
        bcnt_next      = bcnt_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        r_next         = r_reg;
        err_next       = err_reg;
        p1x_next       = p1x_reg;
        p2x_next       = p2x_reg;
        p1y_next       = p1y_reg;
        p2y_next       = p2y_reg;
        qneg_next      = qneg_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        out_free       = !out_valid_reg || !out_stall;

        e_val = r_reg - W'(x_reg);
        mag_r = r_reg[W-1] ? -r_reg : r_reg;
        mag_e = err_reg[W-1] ? -err_reg : err_reg;
        me    = (mag_e > CAP_E) ? CAP_E[MW-1:0] : mag_e[MW-1:0];
        div_num = {me, {FRAC_BITS{1'b0}}};
        div_den = mag_r;

        // bisection bound update
        t0n   = e_val[W-1] ? t_reg : t0_reg;
        t1n   = e_val[W-1] ? t1_reg : t_reg;
        tdiff = t1n - t0n;

        t_ext   = NW'(t_reg);
        one_ext = NW'(ONE_T);

        if (r_reg > LIM_HI)
            ysat = LIM_HI;
        else if (r_reg < LIM_LO)
            ysat = LIM_LO;
        else
            ysat = r_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = p_clamp;
                    t_next     = p_clamp;
                    state_next = S_DONE;
                    r_next     = W'(p_clamp);
                    p1x_next   = cxc1;
                    p1y_next   = W'($signed(cy1_reg));
                    p2x_next   = cxc2;
                    p2y_next   = W'($signed(cy2_reg));
                    case (mode_reg)
                        cbe_pkg::MODE_EASE_IN:
                        begin
                            p1x_next = H42;
                            p1y_next = '0;
                            p2x_next = ONE_S;
                            p2y_next = ONE_S;
                        end
                        cbe_pkg::MODE_EASE_OUT:
                        begin
                            p1x_next = '0;
                            p1y_next = '0;
                            p2x_next = H58;
                            p2y_next = ONE_S;
                        end
                        cbe_pkg::MODE_EASE_IN_OUT:
                        begin
                            p1x_next = H42;
                            p1y_next = '0;
                            p2x_next = H58;
                            p2y_next = ONE_S;
                        end
                        cbe_pkg::MODE_EASE:
                        begin
                            p1x_next = H25;
                            p1y_next = H10;
                            p2x_next = H25;
                            p2y_next = ONE_S;
                        end
                        default: ;
                    endcase
                    case (mode_reg) inside
                        cbe_pkg::MODE_HOLD:
                            r_next = (p_clamp == ONE_T) ? ONE_S : '0;
                        cbe_pkg::MODE_EASE_IN, cbe_pkg::MODE_EASE_OUT,
                        cbe_pkg::MODE_EASE_IN_OUT, cbe_pkg::MODE_EASE,
                        cbe_pkg::MODE_CUSTOM:
                        begin
                            // end points need no solving
                            if (p_clamp != '0 && p_clamp != ONE_T)
                                state_next = S_SETUP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP:
            begin
                ph_next    = PH_NEWTON;
                ncnt_next  = '0;
                state_next = S_P1;
            end
            S_P1, S_P2, S_S1:
            begin
                r_next = mul_sum;
                unique case (state_reg)
                    S_P1:    state_next = S_P2;
                    S_P2:    state_next = S_P3;
                    default: state_next = S_S2;
                endcase
            end
            S_P3:
            begin
                r_next     = mul_sum;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (ph_reg == PH_YEVAL)
                    state_next = S_DONE;
                else if (e_val <= TOL && e_val >= -TOL)
                begin
                    ph_next    = PH_YEVAL;
                    state_next = S_P1;
                end
                else if (ph_reg == PH_NEWTON)
                begin
                    err_next   = e_val;
                    state_next = S_S1;
                end
                else
                begin
                    t0_next   = t0n;
                    t1_next   = t1n;
                    t_next    = t0n + (tdiff >> 1);
                    bcnt_next = bcnt_reg + 1'b1;
                    if (bcnt_reg == BCW'(BISECT_STEPS - 1))
                        ph_next = PH_YEVAL;
                    state_next = S_P1;
                end
            end
            S_S2:
            begin
                r_next     = mul_sum;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (r_reg <= TOL && r_reg >= -TOL)
                begin
                    // flat slope: fall back to bisection
                    ph_next    = PH_BISECT;
                    bcnt_next  = '0;
                    t_next     = x_reg;
                    t0_next    = '0;
                    t1_next    = ONE_T;
                    state_next = S_P1;
                end
                else
                begin
                    div_start  = 1'b1;
                    qneg_next  = err_reg[W-1] ^ r_reg[W-1];
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                // t -= q, saturated to [0, ONE]
                if (qneg_reg)
                    t_next = (q_val > one_ext - t_ext) ? ONE_T
                                                       : t_reg + q_val[TW-1:0];
                else
                    t_next = (q_val > t_ext) ? '0 : t_reg - q_val[TW-1:0];
                ncnt_next  = ncnt_reg + 1'b1;
                state_next = S_P1;
                if (ncnt_reg == NCW'(NEWTON_STEPS - 1))
                begin
                    ph_next   = PH_BISECT;
                    bcnt_next = '0;
                    t_next    = x_reg;
                    t0_next   = '0;
                    t1_next   = ONE_T;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = ysat[cbe_pkg::PROG_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_NEWTON;
            ncnt_reg      <= '0;
            bcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            ncnt_reg      <= ncnt_next;
            bcnt_reg      <= bcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        t_reg    <= t_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        r_reg    <= r_next;
        err_reg  <= err_next;
        p1x_reg  <= p1x_next;
        p2x_reg  <= p2x_next;
        p1y_reg  <= p1y_next;
        p2y_reg  <= p2y_next;
        qneg_reg <= qneg_next;
        out_reg  <= out_next;
    end

    assign in_stall       = (state_reg != S_IDLE) || div_sts.busy;
    assign out_valid      = out_valid_reg;
    assign eased_progress = out_reg;

endmodule
